FILE: hdl/etmm_pkg.sv
// shared types, constants and helpers for the euler trs model matrix block
`default_nettype none
package etmm_pkg;

  localparam int unsigned MaxStages = 24;
  localparam int unsigned TrigW     = 34;
  localparam int unsigned ProdW     = 2 * TrigW;

  localparam logic signed [TrigW-1:0] CordicGain = 34'sd652032874;
  localparam logic [31:0]             Deg2RadQ32 = 32'd74961321;

  typedef logic signed [TrigW-1:0] trig_t;

  // atan(2^-i) in Q30, truncated
  function automatic trig_t atan_q30(input int unsigned i);
    case (i)
      0:  atan_q30 = 34'sd843314856;
      1:  atan_q30 = 34'sd497837829;
      2:  atan_q30 = 34'sd263043836;
      3:  atan_q30 = 34'sd133525158;
      4:  atan_q30 = 34'sd67021686;
      5:  atan_q30 = 34'sd33543515;
      6:  atan_q30 = 34'sd16775850;
      7:  atan_q30 = 34'sd8388437;
      8:  atan_q30 = 34'sd4194282;
      9:  atan_q30 = 34'sd2097149;
      10: atan_q30 = 34'sd1048575;
      11: atan_q30 = 34'sd524287;
      12: atan_q30 = 34'sd262143;
      13: atan_q30 = 34'sd131071;
      14: atan_q30 = 34'sd65535;
      15: atan_q30 = 34'sd32767;
      16: atan_q30 = 34'sd16383;
      17: atan_q30 = 34'sd8191;
      18: atan_q30 = 34'sd4095;
      19: atan_q30 = 34'sd2047;
      20: atan_q30 = 34'sd1023;
      21: atan_q30 = 34'sd511;
      22: atan_q30 = 34'sd255;
      23: atan_q30 = 34'sd127;
      default: atan_q30 = '0;
    endcase
  endfunction

  // q30 product rounded half up, kept at trig width
  function automatic trig_t mul30(input trig_t a, input trig_t b);
    logic signed [ProdW-1:0] p;
    p = ProdW'(a) * ProdW'(b) + (ProdW'(1) <<< 29);
    mul30 = TrigW'(p >>> 30);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/euler_trs_model_matrix_top.sv
// euler trs model matrix: pipelined angle reduction, cordic and matrix products
//
//  channel | valid    | stall    | payload
//  in      | valid_i  | stall_o  | pos_*, *_deg, scale_*
//  out     | valid_o  | stall_i  | m_r*_c*, trans_*
//
// one transaction per cycle unless stalled; the pipeline runs through reduce, quadrant split, rad,
// cordic stages, quadrant map and 3 product stages
// rst_ni clears the valid bits only; payload registers are not reset
// a stall holds each valid stage with no bubble below it; stall_o follows stall_i when the
// pipeline is full of valid transactions and otherwise bubbles absorb it
`default_nettype none
module euler_trs_model_matrix_top #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned TRIG_STAGES = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                valid_i,
  output logic               stall_o,
  input  wire  signed [31:0] pos_x_i,
  input  wire  signed [31:0] pos_y_i,
  input  wire  signed [31:0] pos_z_i,
  input  wire  signed [31:0] pitch_deg_i,
  input  wire  signed [31:0] yaw_deg_i,
  input  wire  signed [31:0] roll_deg_i,
  input  wire  signed [31:0] scale_x_i,
  input  wire  signed [31:0] scale_y_i,
  input  wire  signed [31:0] scale_z_i,
  output logic               valid_o,
  input  wire                stall_i,
  output logic signed [31:0] m_r0_c0_o,
  output logic signed [31:0] m_r0_c1_o,
  output logic signed [31:0] m_r0_c2_o,
  output logic signed [31:0] m_r1_c0_o,
  output logic signed [31:0] m_r1_c1_o,
  output logic signed [31:0] m_r1_c2_o,
  output logic signed [31:0] m_r2_c0_o,
  output logic signed [31:0] m_r2_c1_o,
  output logic signed [31:0] m_r2_c2_o,
  output logic signed [31:0] trans_x_o,
  output logic signed [31:0] trans_y_o,
  output logic signed [31:0] trans_z_o
);
  import etmm_pkg::*;

  localparam int unsigned NS    = (TRIG_STAGES < MaxStages) ? TRIG_STAGES : MaxStages;
  localparam int unsigned NPIPE = NS + 7;
  localparam int unsigned AW    = 42;
  localparam logic signed [AW-1:0] Full    = AW'(360) <<< FRAC_BITS;
  localparam logic signed [AW-1:0] Quarter = AW'(90) <<< FRAC_BITS;

  // full turn is 45 << SH: reduce the upper angle bits modulo 45
  localparam int unsigned SH      = FRAC_BITS + 3;
  localparam int unsigned HW      = 32 - SH;
  localparam int unsigned RS      = HW + 6;
  localparam longint unsigned RecipL = ((64'd1 << RS) + 64'd44) / 64'd45;
  localparam logic [RS+HW-1:0] Recip = (RS+HW)'(RecipL);
  localparam int unsigned HalfMod = (1 << (HW - 1)) % 45;

  // valid bits of every stage; stage k advances unless it is held
  logic [NPIPE-1:0] v_q;
  logic [NPIPE:0]   adv;
  always_comb begin
    adv[NPIPE] = !stall_i || !v_q[NPIPE-1];
    for (int k = NPIPE - 1; k >= 1; k--) begin
      adv[k] = adv[k+1] || !v_q[k-1];
    end
    adv[0] = adv[1];
  end
  assign stall_o = !adv[0];
  assign valid_o = v_q[NPIPE-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NPIPE; k++) begin
        if (adv[k+1]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // side data carried down the pipe: position and scale
  logic signed [31:0] pos_q [NPIPE][3];
  logic signed [31:0] scl_q [NPIPE][3];
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      pos_q[0][0] <= pos_x_i;   pos_q[0][1] <= pos_y_i;   pos_q[0][2] <= pos_z_i;
      scl_q[0][0] <= scale_x_i; scl_q[0][1] <= scale_y_i; scl_q[0][2] <= scale_z_i;
    end
    for (int k = 1; k < NPIPE; k++) begin
      if (adv[k+1]) begin
        pos_q[k] <= pos_q[k-1];
        scl_q[k] <= scl_q[k-1];
      end
    end
  end

  // stage 0: upper angle bits (offset to unsigned) modulo 45 by reciprocal
  logic signed [31:0] ang_in [3];
  assign ang_in[0] = pitch_deg_i;
  assign ang_in[1] = yaw_deg_i;
  assign ang_in[2] = roll_deg_i;
  logic [5:0]    r0_q  [3];
  logic [SH-1:0] lo0_q [3];
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      for (int a = 0; a < 3; a++) begin
        logic [HW-1:0]    hu;
        logic [RS+HW-1:0] prod;
        logic [HW-1:0]    quo;
        logic [31:0]      diff;
        hu   = {~ang_in[a][31], ang_in[a][30:SH]};
        prod = (RS+HW)'(hu) * Recip;
        quo  = prod[RS +: HW];
        diff = 32'(hu) - 32'(quo) * 32'd45;
        r0_q[a]  <= diff[5:0];
        lo0_q[a] <= ang_in[a][SH-1:0];
      end
    end
  end

  // stage 1: remove the offset, rebuild [0, 360), quadrant and remainder
  logic [1:0]           q1_q [3];
  logic signed [AW-1:0] r1_q [3];
  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      for (int a = 0; a < 3; a++) begin
        logic [5:0]           hm;
        logic signed [AW-1:0] m;
        hm = (r0_q[a] >= 6'(HalfMod)) ? r0_q[a] - 6'(HalfMod)
                                      : r0_q[a] + 6'(45 - HalfMod);
        m = AW'({hm, lo0_q[a]});
        if (m >= 3 * Quarter) begin
          q1_q[a] <= 2'd3; r1_q[a] <= m - 3 * Quarter;
        end else if (m >= 2 * Quarter) begin
          q1_q[a] <= 2'd2; r1_q[a] <= m - 2 * Quarter;
        end else if (m >= Quarter) begin
          q1_q[a] <= 2'd1; r1_q[a] <= m - Quarter;
        end else begin
          q1_q[a] <= 2'd0; r1_q[a] <= m;
        end
      end
    end
  end

  // stage 2: degrees to radians in q30
  logic [1:0] qc_q [NS+1][3];
  trig_t      x_q  [NS+1][3];
  trig_t      y_q  [NS+1][3];
  trig_t      z_q  [NS+1][3];
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int a = 0; a < 3; a++) begin
        logic [63:0] p;
        p = 64'(r1_q[a][31:0]) * 64'(Deg2RadQ32) + (64'd1 << (FRAC_BITS + 1));
        z_q[0][a]  <= TrigW'(p >> (FRAC_BITS + 2));
        x_q[0][a]  <= CordicGain;
        y_q[0][a]  <= '0;
        qc_q[0][a] <= q1_q[a];
      end
    end
  end

  // cordic stages, one per register
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    always_ff @(posedge clk_i) begin
      if (adv[4+i]) begin
        for (int a = 0; a < 3; a++) begin
          if (!z_q[i][a][TrigW-1]) begin
            x_q[i+1][a] <= x_q[i][a] - (y_q[i][a] >>> i);
            y_q[i+1][a] <= y_q[i][a] + (x_q[i][a] >>> i);
            z_q[i+1][a] <= z_q[i][a] - atan_q30(i);
          end else begin
            x_q[i+1][a] <= x_q[i][a] + (y_q[i][a] >>> i);
            y_q[i+1][a] <= y_q[i][a] - (x_q[i][a] >>> i);
            z_q[i+1][a] <= z_q[i][a] + atan_q30(i);
          end
          qc_q[i+1][a] <= qc_q[i][a];
        end
      end
    end
  end

  // quadrant mapping to full-angle cos and sin
  trig_t c_q [3];
  trig_t s_q [3];
  always_ff @(posedge clk_i) begin
    if (adv[NS+4]) begin
      for (int a = 0; a < 3; a++) begin
        case (qc_q[NS][a])
          2'd0: begin c_q[a] <= x_q[NS][a];  s_q[a] <= y_q[NS][a];  end
          2'd1: begin c_q[a] <= -y_q[NS][a]; s_q[a] <= x_q[NS][a];  end
          2'd2: begin c_q[a] <= -x_q[NS][a]; s_q[a] <= -y_q[NS][a]; end
          default: begin c_q[a] <= y_q[NS][a]; s_q[a] <= -x_q[NS][a]; end
        endcase
      end
    end
  end

  // first products: sb*sa, cb*sa and pass the trig values on
  trig_t sbsa_q, cbsa_q;
  trig_t t_q [6];
  always_ff @(posedge clk_i) begin
    if (adv[NS+5]) begin
      sbsa_q <= mul30(s_q[1], s_q[0]);
      cbsa_q <= mul30(c_q[1], s_q[0]);
      t_q[0] <= c_q[0]; t_q[1] <= s_q[0];
      t_q[2] <= c_q[1]; t_q[3] <= s_q[1];
      t_q[4] <= c_q[2]; t_q[5] <= s_q[2];
    end
  end

  // second products: the nine rotation entries
  trig_t e_q [9];
  always_ff @(posedge clk_i) begin
    if (adv[NS+6]) begin
      e_q[0] <= mul30(t_q[2], t_q[4]) + mul30(sbsa_q, t_q[5]);
      e_q[1] <= mul30(sbsa_q, t_q[4]) - mul30(t_q[2], t_q[5]);
      e_q[2] <= mul30(t_q[3], t_q[0]);
      e_q[3] <= mul30(t_q[0], t_q[5]);
      e_q[4] <= mul30(t_q[0], t_q[4]);
      e_q[5] <= -t_q[1];
      e_q[6] <= mul30(cbsa_q, t_q[5]) - mul30(t_q[3], t_q[4]);
      e_q[7] <= mul30(t_q[3], t_q[5]) + mul30(cbsa_q, t_q[4]);
      e_q[8] <= mul30(t_q[2], t_q[0]);
    end
  end

  // scale by column, round and saturate
  logic signed [31:0] o_q [9];
  always_ff @(posedge clk_i) begin
    if (adv[NS+7]) begin
      for (int k = 0; k < 9; k++) begin
        logic signed [ProdW-1:0] p;
        p = (ProdW'(e_q[k]) * ProdW'(scl_q[NS+5][k%3]) + (ProdW'(1) <<< 29)) >>> 30;
        if (p > ProdW'(32'sh7fffffff)) o_q[k] <= 32'sh7fffffff;
        else if (p < -ProdW'(33'sh80000000)) o_q[k] <= 32'sh80000000;
        else o_q[k] <= p[31:0];
      end
    end
  end

  assign m_r0_c0_o = o_q[0]; assign m_r0_c1_o = o_q[1]; assign m_r0_c2_o = o_q[2];
  assign m_r1_c0_o = o_q[3]; assign m_r1_c1_o = o_q[4]; assign m_r1_c2_o = o_q[5];
  assign m_r2_c0_o = o_q[6]; assign m_r2_c1_o = o_q[7]; assign m_r2_c2_o = o_q[8];
  assign trans_x_o = pos_q[NPIPE-1][0];
  assign trans_y_o = pos_q[NPIPE-1][1];
  assign trans_z_o = pos_q[NPIPE-1][2];

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(m_r0_c0_o) && $stable(trans_x_o))
    else $error("output changed under stall");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> stall_i && valid_o)
    else $error("input stalled with room in pipe");
  a_free_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_i |-> !stall_o)
    else $error("stall without downstream stall");
`endif

endmodule
`default_nettype wire
